// ===== design/srfs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srfs_pkg
// Shared widths, codes and the cell control bundle of the frame sender.
// ----------------------------------------------------------------------------
package srfs_pkg;

    localparam int MAX_WINDOW_DEF = 8;

    // Wide enough for any count up to 127
    localparam int CNT_W     = 7;
    localparam int PKT_W     = 16;
    localparam int FRM_W     = 16;
    localparam int MASK_W    = 8;
    localparam int NACK_W    = 4;
    localparam int WIN_W     = 4;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 16;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_TOTAL_PACKETS = 1'b1;

    localparam logic CMD_SEND = 1'b0;
    localparam logic CMD_ACK  = 1'b1;

    localparam logic KIND_SLOT = 1'b0;
    localparam logic KIND_ACK  = 1'b1;

    typedef struct packed {
        logic             slot_load;
        logic             slot_rot;
        logic             rtx_push;
        logic             rtx_pop;
        logic [CNT_W-1:0] fill;
        logic [CNT_W-1:0] tail;
        logic [CNT_W-1:0] rcount;
        logic [PKT_W-1:0] word;
    } cell_ctl_t;

endpackage
`default_nettype wire

// ===== design/srfs_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srfs_if
// Valid/ready channels for command words and result words.
// ----------------------------------------------------------------------------
interface srfs_in_if;
    import srfs_pkg::*;
    logic              valid;
    logic              ready;
    logic              command;
    logic [MASK_W-1:0] nack_mask;

    modport source (output valid, command, nack_mask, input ready);
    modport sink (input valid, command, nack_mask, output ready);
endinterface

interface srfs_out_if;
    import srfs_pkg::*;
    logic              valid;
    logic              ready;
    logic              kind;
    logic              slot_valid;
    logic [PKT_W-1:0]  packet_number;
    logic [FRM_W-1:0]  frame_number;
    logic              last;
    logic [NACK_W-1:0] nack_count;
    logic              all_done;

    modport source (output valid, kind, slot_valid, packet_number, frame_number, last,
                    nack_count, all_done, input ready);
    modport sink (input valid, kind, slot_valid, packet_number, frame_number, last,
                  nack_count, all_done, output ready);
endinterface
`default_nettype wire

// ===== design/srfs_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srfs_cell
// One window position: a frame slot and a retransmit queue entry.
// ----------------------------------------------------------------------------
module srfs_cell #(
    parameter int IDX = 0
) (
    input  wire logic                      clk,
    input  wire srfs_pkg::cell_ctl_t       ctl,
    input  wire logic [srfs_pkg::PKT_W-1:0] slot_from_next,
    input  wire logic [srfs_pkg::PKT_W-1:0] slot_from_head,
    input  wire logic [srfs_pkg::PKT_W-1:0] rtx_from_next,
    output logic      [srfs_pkg::PKT_W-1:0] slot_q,
    output logic      [srfs_pkg::PKT_W-1:0] rtx_q
);
    import srfs_pkg::*;

    localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

    logic [PKT_W-1:0] slot_reg;
    logic [PKT_W-1:0] rtx_reg;

    // Frame slot: load at the fill position, or rotate within the filled frame
    always_ff @(posedge clk)
    begin
        if (ctl.slot_load && ctl.fill == MY_IDX)
        begin
            slot_reg <= ctl.word;
        end
        else if (ctl.slot_rot)
        begin
            slot_reg <= (ctl.tail == MY_IDX) ? slot_from_head : slot_from_next;
        end
    end

    // Retransmit entry: append at the queue tail, or advance toward the head
    always_ff @(posedge clk)
    begin
        if (ctl.rtx_push && ctl.rcount == MY_IDX)
        begin
            rtx_reg <= ctl.word;
        end
        else if (ctl.rtx_pop)
        begin
            rtx_reg <= rtx_from_next;
        end
    end

    assign slot_q = slot_reg;
    assign rtx_q  = rtx_reg;

endmodule
`default_nettype wire

// ===== design/selective_repeat_frame_sender.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// selective_repeat_frame_sender
// Sender side of a selective-repeat window built on a row of slot cells.
// ----------------------------------------------------------------------------
// One command word is taken at a time. A send that builds or replays a frame
// of n slots gives one result word per cycle while the result port is free;
// a replay moves the row of cells one slot to its head for each word. An
// acknowledgement walks the filled slots one per cycle and then gives one
// status word; an all-done result or an acknowledgement with no frame
// outstanding gives just that word. A stalled result port holds the sender.
// The next command is taken as soon as the last result is in the output
// register. window_size 0 acts as 1 and values above MAX_WINDOW as MAX_WINDOW.
// ----------------------------------------------------------------------------
module selective_repeat_frame_sender #(
    parameter int MAX_WINDOW = srfs_pkg::MAX_WINDOW_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    srfs_in_if.sink                            item,
    srfs_out_if.source                         result,
    input  wire logic                          cfg_we,
    input  wire logic [srfs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [srfs_pkg::CFG_W-1:0]     cfg_data
);
    import srfs_pkg::*;

    localparam int CW = $clog2(MAX_WINDOW + 1);
    localparam logic [CW-1:0] WMAX = CW'(MAX_WINDOW);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_BUILD  = 3'd1;
    localparam logic [2:0] ST_REPLAY = 3'd2;
    localparam logic [2:0] ST_ACK    = 3'd3;
    localparam logic [2:0] ST_STATUS = 3'd4;

    logic [WIN_W-1:0]  window_reg;
    logic [PKT_W-1:0]  total_reg;

    logic [2:0]        state_reg, state_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [CW-1:0]     filled_reg, filled_next;
    logic [CW-1:0]     rcount_reg, rcount_next;
    logic [PKT_W-1:0]  fresh_reg, fresh_next;
    logic [FRM_W-1:0]  frame_reg, frame_next;
    logic [MASK_W-1:0] mask_reg, mask_next;
    logic [NACK_W-1:0] nacks_reg, nacks_next;
    logic              stat_kind_reg, stat_kind_next;
    logic              adv_reg, adv_next;

    logic              out_valid_reg, out_valid_next;
    logic              out_kind_reg, out_kind_next;
    logic              out_slot_valid_reg, out_slot_valid_next;
    logic [PKT_W-1:0]  out_pkt_reg, out_pkt_next;
    logic [FRM_W-1:0]  out_frame_reg, out_frame_next;
    logic              out_last_reg, out_last_next;
    logic [NACK_W-1:0] out_nacks_reg, out_nacks_next;
    logic              out_done_reg, out_done_next;

    cell_ctl_t         ctl;
    logic [PKT_W-1:0]  slot_q [MAX_WINDOW];
    logic [PKT_W-1:0]  rtx_q  [MAX_WINDOW];

    logic [CW-1:0]     w_eff;
    logic [CW-1:0]     cnt_inc;
    logic              finished;
    logic              out_free;

    // ------------------------------------------------------------------
    // Cell row
    // ------------------------------------------------------------------
    for (genvar i = 0; i < MAX_WINDOW; i++)
    begin : g_cell
        logic [PKT_W-1:0] slot_nb;
        logic [PKT_W-1:0] rtx_nb;

        if (i == MAX_WINDOW - 1)
        begin : g_end
            assign slot_nb = slot_q[0];
            assign rtx_nb  = rtx_q[i];
        end
        else
        begin : g_mid
            assign slot_nb = slot_q[i + 1];
            assign rtx_nb  = rtx_q[i + 1];
        end

        srfs_cell #(
            .IDX (i)
        ) u_cell (
            .clk            (clk),
            .ctl            (ctl),
            .slot_from_next (slot_nb),
            .slot_from_head (slot_q[0]),
            .rtx_from_next  (rtx_nb),
            .slot_q         (slot_q[i]),
            .rtx_q          (rtx_q[i])
        );
    end

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= WIN_W'(4);
            total_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_WINDOW_SIZE:   window_reg <= cfg_data[WIN_W-1:0];
                REG_TOTAL_PACKETS: total_reg  <= cfg_data[PKT_W-1:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        if (window_reg == '0)
        begin
            w_eff = CW'(1);
        end
        else if (int'(window_reg) > MAX_WINDOW)
        begin
            w_eff = WMAX;
        end
        else
        begin
            w_eff = CW'(window_reg);
        end
    end

    assign cnt_inc  = cnt_reg + CW'(1);
    assign finished = (fresh_reg >= total_reg) && (rcount_reg == '0);
    assign out_free = !out_valid_reg || result.ready;

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        logic             take_rtx;
        logic             is_last;
        logic [CW-1:0]    rc_after;
        logic [PKT_W:0]   fresh_after;

        state_next     = state_reg;
        cnt_next       = cnt_reg;
        filled_next    = filled_reg;
        rcount_next    = rcount_reg;
        fresh_next     = fresh_reg;
        frame_next     = frame_reg;
        mask_next      = mask_reg;
        nacks_next     = nacks_reg;
        stat_kind_next = stat_kind_reg;
        adv_next       = adv_reg;

        out_valid_next      = out_valid_reg && !result.ready;
        out_kind_next       = out_kind_reg;
        out_slot_valid_next = out_slot_valid_reg;
        out_pkt_next        = out_pkt_reg;
        out_frame_next      = out_frame_reg;
        out_last_next       = out_last_reg;
        out_nacks_next      = out_nacks_reg;
        out_done_next       = out_done_reg;

        ctl           = '0;
        ctl.fill      = CNT_W'(cnt_reg);
        ctl.tail      = CNT_W'(filled_reg - CW'(1));
        ctl.rcount    = CNT_W'(rcount_reg);

        take_rtx    = rcount_reg != '0;
        rc_after    = rcount_reg;
        fresh_after = {1'b0, fresh_reg};
        is_last     = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (item.valid)
                begin
                    cnt_next   = '0;
                    nacks_next = '0;
                    if (item.command == CMD_SEND)
                    begin
                        if (filled_reg != '0)
                        begin
                            state_next = ST_REPLAY;
                        end
                        else if (finished)
                        begin
                            stat_kind_next = KIND_SLOT;
                            adv_next       = 1'b0;
                            state_next     = ST_STATUS;
                        end
                        else
                        begin
                            state_next = ST_BUILD;
                        end
                    end
                    else
                    begin
                        stat_kind_next = KIND_ACK;
                        mask_next      = item.nack_mask;
                        if (filled_reg != '0)
                        begin
                            adv_next   = 1'b1;
                            state_next = ST_ACK;
                        end
                        else
                        begin
                            adv_next   = 1'b0;
                            state_next = ST_STATUS;
                        end
                    end
                end
            end

            ST_BUILD:
            begin
                if (out_free)
                begin
                    // Queued retransmissions first, then fresh packets
                    ctl.slot_load = 1'b1;
                    if (take_rtx)
                    begin
                        ctl.word    = rtx_q[0];
                        ctl.rtx_pop = 1'b1;
                        rc_after    = rcount_reg - CW'(1);
                    end
                    else
                    begin
                        ctl.word    = fresh_reg;
                        fresh_after = {1'b0, fresh_reg} + (PKT_W + 1)'(1);
                    end
                    rcount_next = rc_after;
                    fresh_next  = fresh_after[PKT_W-1:0];
                    is_last     = (cnt_inc == w_eff) ||
                                  ((rc_after == '0) && (fresh_after >= {1'b0, total_reg}));

                    out_valid_next      = 1'b1;
                    out_kind_next       = KIND_SLOT;
                    out_slot_valid_next = 1'b1;
                    out_pkt_next        = ctl.word;
                    out_frame_next      = frame_reg;
                    out_last_next       = is_last;
                    out_nacks_next      = '0;
                    out_done_next       = 1'b0;

                    cnt_next = cnt_inc;
                    if (is_last)
                    begin
                        filled_next = cnt_inc;
                        state_next  = ST_IDLE;
                    end
                end
            end

            ST_REPLAY:
            begin
                if (out_free)
                begin
                    // A full turn of the rotation leaves the frame in place
                    ctl.slot_rot = 1'b1;
                    is_last      = cnt_inc == filled_reg;

                    out_valid_next      = 1'b1;
                    out_kind_next       = KIND_SLOT;
                    out_slot_valid_next = 1'b1;
                    out_pkt_next        = slot_q[0];
                    out_frame_next      = frame_reg;
                    out_last_next       = is_last;
                    out_nacks_next      = '0;
                    out_done_next       = 1'b0;

                    cnt_next = cnt_inc;
                    if (is_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            ST_ACK:
            begin
                ctl.slot_rot = 1'b1;
                if (mask_reg[0] && rcount_reg < WMAX)
                begin
                    ctl.rtx_push = 1'b1;
                    ctl.word     = slot_q[0];
                    rcount_next  = rcount_reg + CW'(1);
                    nacks_next   = nacks_reg + NACK_W'(1);
                end
                mask_next = mask_reg >> 1;
                cnt_next  = cnt_inc;
                if (cnt_inc == filled_reg)
                begin
                    state_next = ST_STATUS;
                end
            end

            ST_STATUS:
            begin
                if (out_free)
                begin
                    out_valid_next      = 1'b1;
                    out_kind_next       = stat_kind_reg;
                    out_slot_valid_next = 1'b0;
                    out_pkt_next        = '0;
                    out_frame_next      = frame_reg;
                    out_last_next       = 1'b1;
                    out_nacks_next      = nacks_reg;
                    out_done_next       = finished;
                    if (adv_reg)
                    begin
                        frame_next  = frame_reg + FRM_W'(1);
                        filled_next = '0;
                    end
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            filled_reg    <= '0;
            rcount_reg    <= '0;
            fresh_reg     <= '0;
            frame_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            filled_reg    <= filled_next;
            rcount_reg    <= rcount_next;
            fresh_reg     <= fresh_next;
            frame_reg     <= frame_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mask_reg           <= mask_next;
        nacks_reg          <= nacks_next;
        stat_kind_reg      <= stat_kind_next;
        adv_reg            <= adv_next;
        out_kind_reg       <= out_kind_next;
        out_slot_valid_reg <= out_slot_valid_next;
        out_pkt_reg        <= out_pkt_next;
        out_frame_reg      <= out_frame_next;
        out_last_reg       <= out_last_next;
        out_nacks_reg      <= out_nacks_next;
        out_done_reg       <= out_done_next;
    end

    assign item.ready           = state_reg == ST_IDLE;
    assign result.valid         = out_valid_reg;
    assign result.kind          = out_kind_reg;
    assign result.slot_valid    = out_slot_valid_reg;
    assign result.packet_number = out_pkt_reg;
    assign result.frame_number  = out_frame_reg;
    assign result.last          = out_last_reg;
    assign result.nack_count    = out_nacks_reg;
    assign result.all_done      = out_done_reg;

endmodule
`default_nettype wire

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the selective-repeat frame sender. A scoreboard
// class predicts every result word from the accepted command words and the
// register settings. Directed frames and randomized phases with idling on
// both sides drive the block.
// ----------------------------------------------------------------------------
import srfs_pkg::*;

typedef struct {
    logic              kind;
    logic              slot_valid;
    logic [PKT_W-1:0]  packet_number;
    logic [FRM_W-1:0]  frame_number;
    logic              last;
    logic [NACK_W-1:0] nack_count;
    logic              all_done;
} result_word_t;

class arq_sender_scoreboard;
    bit [WIN_W-1:0]  window_reg;
    bit [PKT_W-1:0]  total_reg;
    int unsigned     next_fresh;
    bit [FRM_W-1:0]  frame_ctr;
    bit [PKT_W-1:0]  rtx_list[MAX_WINDOW_DEF];
    int unsigned     rtx_count;
    bit [PKT_W-1:0]  slots[MAX_WINDOW_DEF];
    int unsigned     filled;
    result_word_t    pending_words[$];
    int unsigned     errors;
    int unsigned     checked;

    function new();
        window_reg = 4;
        total_reg  = 0;
        next_fresh = 0;
        frame_ctr  = 0;
        rtx_count  = 0;
        filled     = 0;
        errors     = 0;
        checked    = 0;
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
        if (idx == REG_WINDOW_SIZE)
            window_reg = value[WIN_W-1:0];
        else if (idx == REG_TOTAL_PACKETS)
            total_reg = value[PKT_W-1:0];
    endfunction

    function bit all_sent();
        return (next_fresh >= total_reg) && (rtx_count == 0);
    endfunction

    function void push_word(logic kind, logic sv, logic [PKT_W-1:0] pkt,
                            logic [FRM_W-1:0] frm, logic last, logic [NACK_W-1:0] nk,
                            logic done);
        result_word_t w;
        w.kind          = kind;
        w.slot_valid    = sv;
        w.packet_number = pkt;
        w.frame_number  = frm;
        w.last          = last;
        w.nack_count    = nk;
        w.all_done      = done;
        pending_words.push_back(w);
    endfunction

    function void take_command(logic cmd, logic [MASK_W-1:0] mask);
        int unsigned     w;
        int unsigned     taken;
        int unsigned     count;
        int unsigned     nacks;
        bit [FRM_W-1:0]  frm;
        if (cmd == CMD_SEND) begin
            if (filled == 0) begin
                w = window_reg;
                if (w < 1)
                    w = 1;
                if (w > MAX_WINDOW_DEF)
                    w = MAX_WINDOW_DEF;
                if (all_sent()) begin
                    push_word(KIND_SLOT, 1'b0, '0, frame_ctr, 1'b1, '0, 1'b1);
                    return;
                end
                taken = (rtx_count < w) ? rtx_count : w;
                count = 0;
                for (int i = 0; i < taken; i++)
                    slots[count++] = rtx_list[i];
                // shift the leftover retransmits to the head, keeping order
                for (int i = taken; i < rtx_count; i++)
                    rtx_list[i - taken] = rtx_list[i];
                rtx_count -= taken;
                while (count < w && next_fresh < total_reg) begin
                    slots[count++] = PKT_W'(next_fresh);
                    next_fresh++;
                end
                filled = count;
            end
            for (int i = 0; i < filled; i++)
                push_word(KIND_SLOT, 1'b1, slots[i], frame_ctr, (i + 1 == filled), '0, 1'b0);
        end
        else begin
            nacks = 0;
            frm   = frame_ctr;
            if (filled != 0) begin
                for (int i = 0; i < filled; i++) begin
                    if (mask[i] && rtx_count < MAX_WINDOW_DEF) begin
                        rtx_list[rtx_count++] = slots[i];
                        nacks++;
                    end
                end
                filled = 0;
                frame_ctr++;
            end
            push_word(KIND_ACK, 1'b0, '0, frm, 1'b1, NACK_W'(nacks), all_sent());
        end
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    function void check_word(result_word_t got);
        result_word_t want;
        if (pending_words.size() == 0) begin
            $error("result word with no prediction waiting: kind %0d packet %0d frame %0d",
                   got.kind, got.packet_number, got.frame_number);
            errors++;
            return;
        end
        want = pending_words.pop_front();
        checked++;
        compare_field("kind", want.kind, got.kind);
        compare_field("slot_valid", want.slot_valid, got.slot_valid);
        compare_field("packet_number", want.packet_number, got.packet_number);
        compare_field("frame_number", want.frame_number, got.frame_number);
        compare_field("last", want.last, got.last);
        compare_field("nack_count", want.nack_count, got.nack_count);
        compare_field("all_done", want.all_done, got.all_done);
    endfunction
endclass

module testbench;
    localparam int          SETTLE    = 16;
    localparam int          LONG_HOLD = 300;
    localparam int unsigned LIMIT     = 300_000;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    srfs_in_if  cmd_ch ();
    srfs_out_if res_ch ();

    selective_repeat_frame_sender u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (cmd_ch),
        .result    (res_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    arq_sender_scoreboard sb;
    bit          quick;
    bit          hold_request;
    int unsigned words_sent;
    int unsigned settings_used;
    int unsigned cycles;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > LIMIT)
            begin
                $display("testbench NOT OK");
                $finish;
            end
        end
    end

    function automatic int draw_gap();
        if (quick || $urandom_range(0, 3) == 0)
            return 0;
        return $urandom_range(0, 18);
    endfunction

    task automatic offer_command(logic cmd, logic [MASK_W-1:0] mask, int gap);
        if (gap > 0)
        begin
            @(negedge clk);
            cmd_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        cmd_ch.valid     <= 1'b1;
        cmd_ch.command   <= cmd;
        cmd_ch.nack_mask <= mask;
        do @(posedge clk); while (cmd_ch.ready !== 1'b1);
        sb.take_command(cmd, mask);
        words_sent++;
    endtask

    // drop valid and hold until every predicted word has come back
    task automatic wait_results_drained();
        @(negedge clk);
        cmd_ch.valid <= 1'b0;
        while (sb.pending_words.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        sb.write_register(idx, value);
        settings_used++;
    endtask

    // result side: random stalls, one long hold-off on request
    initial
    begin
        int           gap;
        result_word_t got;
        res_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            gap = draw_gap();
            if (hold_request)
            begin
                gap          = LONG_HOLD;
                hold_request = 1'b0;
            end
            if (gap > 0)
            begin
                @(negedge clk);
                res_ch.ready <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            @(negedge clk);
            res_ch.ready <= 1'b1;
            do @(posedge clk); while (res_ch.valid !== 1'b1);
            got.kind          = res_ch.kind;
            got.slot_valid    = res_ch.slot_valid;
            got.packet_number = res_ch.packet_number;
            got.frame_number  = res_ch.frame_number;
            got.last          = res_ch.last;
            got.nack_count    = res_ch.nack_count;
            got.all_done      = res_ch.all_done;
            sb.check_word(got);
        end
    end

    initial
    begin
        logic [WIN_W-1:0]  win_cfg[6];
        logic [PKT_W-1:0]  tot_cfg[6];
        logic              cmd;
        sb               = new();
        quick            = 1'b0;
        hold_request     = 1'b0;
        words_sent       = 0;
        settings_used    = 0;
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = '0;
        cfg_data         = '0;
        cmd_ch.valid     = 1'b0;
        cmd_ch.command   = CMD_SEND;
        cmd_ch.nack_mask = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // nothing to send yet, then an ack with no frame outstanding
        offer_command(CMD_SEND, 8'h00, draw_gap());
        offer_command(CMD_ACK, 8'hFF, draw_gap());
        wait_results_drained();
        write_register(REG_TOTAL_PACKETS, 16'd10);
        write_register(REG_WINDOW_SIZE, 16'hFFF4);
        offer_command(CMD_SEND, 8'h00, draw_gap());
        // replay of the outstanding frame
        offer_command(CMD_SEND, 8'hFF, draw_gap());
        offer_command(CMD_ACK, 8'hFF, draw_gap());
        offer_command(CMD_SEND, 8'h00, draw_gap());
        offer_command(CMD_ACK, 8'h00, draw_gap());
        wait_results_drained();
        write_register(REG_WINDOW_SIZE, 16'h0008);
        // short frame at the end of the fresh packets; high mask bits ignored
        offer_command(CMD_SEND, 8'h00, draw_gap());
        offer_command(CMD_ACK, 8'hA5, draw_gap());
        wait_results_drained();
        // lower the window below the retransmit backlog
        write_register(REG_WINDOW_SIZE, 16'h0001);
        offer_command(CMD_SEND, 8'h00, draw_gap());
        offer_command(CMD_ACK, 8'h00, draw_gap());
        offer_command(CMD_SEND, 8'h00, draw_gap());
        offer_command(CMD_ACK, 8'h01, draw_gap());
        wait_results_drained();
        write_register(REG_WINDOW_SIZE, 16'h5A50);
        offer_command(CMD_SEND, 8'h00, draw_gap());
        offer_command(CMD_ACK, 8'h00, draw_gap());
        offer_command(CMD_ACK, 8'h5A, draw_gap());
        wait_results_drained();
        write_register(REG_WINDOW_SIZE, 16'h000F);
        offer_command(CMD_SEND, 8'h00, draw_gap());
        offer_command(CMD_ACK, 8'h00, draw_gap());
        offer_command(CMD_SEND, 8'h00, draw_gap());
        offer_command(CMD_ACK, 8'h80, draw_gap());

        win_cfg = '{4'd8, 4'd1, 4'd0, 4'd15, 4'd5, 4'($urandom_range(0, 15))};
        tot_cfg = '{16'hFFFF, 16'd40, 16'd6, 16'd90, 16'($urandom_range(0, 65535)),
                    16'($urandom_range(0, 60))};
        for (int p = 0; p < 6; p++)
        begin
            wait_results_drained();
            write_register(REG_WINDOW_SIZE, {12'($urandom_range(0, 4095)), win_cfg[p]});
            write_register(REG_TOTAL_PACKETS, tot_cfg[p]);
            quick = (p == 2);
            if (p == 0)
                hold_request = 1'b1;
            for (int n = 0; n < 25; n++)
            begin
                // mostly well-formed send/ack pairs, some replays and stray acks
                if ($urandom_range(0, 9) < 8)
                    cmd = (sb.filled != 0) ? CMD_ACK : CMD_SEND;
                else
                    cmd = 1'($urandom_range(0, 1));
                offer_command(cmd, 8'($urandom_range(0, 255)), draw_gap());
            end
        end

        wait_results_drained();
        repeat (SETTLE) @(posedge clk);
        $display("Run covered %0d command words, %0d result words checked, %0d register writes.",
                 words_sent, sb.checked, settings_used);
        $display("Ended at frame %0d with next fresh packet %0d.",
                 sb.frame_ctr, sb.next_fresh);
        if (sb.errors == 0 && sb.pending_words.size() == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end
endmodule
